>>> src/cbpsu_pkg.sv
// cbpsu_pkg: shared types and codes for the prefixed bit/shift/rotate unit.
// Holds the beat structs, operation enums and register-select constants.
// No dependencies.
package cbpsu_pkg;

  // register file geometry
  localparam int unsigned NumRegs   = 7;
  localparam int unsigned RegIdxW   = 3;
  localparam logic [2:0]  SelMem    = 3'd6;   // operand select for the memory byte
  localparam logic [2:0]  SelA      = 3'd7;   // operand select for A
  localparam logic [2:0]  RegFlags  = 3'd6;   // reg_index for the flags register
  localparam logic [2:0]  SlotA     = 3'd6;   // storage slot of A
  localparam logic [7:0]  FlagsMask = 8'hF0;  // flags live in bits 7:4 on load/read

  // item operation
  typedef enum logic [1:0] {
    OP_EXEC = 2'd0,
    OP_LOAD = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // opcode bits 7:6
  typedef enum logic [1:0] {
    CLS_SHIFT = 2'd0,
    CLS_BIT   = 2'd1,
    CLS_RES   = 2'd2,
    CLS_SET   = 2'd3
  } cls_e;

  // opcode bits 5:3 when the class is shift
  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_e;

  // input beat
  typedef struct packed {
    op_e        op;
    logic [7:0] opcode;
    logic [7:0] mem_byte;
    logic [2:0] reg_index;
    logic [7:0] load_value;
  } in_t;

  // result beat
  typedef struct packed {
    logic [7:0] value;
    logic [3:0] flags_now;
    logic       mem_write;
  } out_t;

  // state update from the execute logic
  typedef struct packed {
    logic               rf_we;
    logic [RegIdxW-1:0] rf_waddr;
    logic [7:0]         rf_wdata;
    logic [3:0]         flags;
  } upd_t;

  // operand select or register index (not flags/memory) to storage slot
  function automatic logic [RegIdxW-1:0] slot_of(input logic [2:0] sel);
    slot_of = (sel == SelA) ? SlotA : sel;
  endfunction

endpackage

>>> src/cbpsu_exec.sv
// cbpsu_exec: combinational execute logic for one item.
// Computes the result beat and the register/flag update from the operand read.
// Depends on cbpsu_pkg.
module cbpsu_exec import cbpsu_pkg::*; (
  input  in_t                item_i,
  input  logic [7:0]         rf_rdata_i,
  input  logic [3:0]         flags_i,
  output logic [RegIdxW-1:0] rf_raddr_o,
  output out_t               result_o,
  output upd_t               upd_o
);

  logic [2:0] sel;
  logic [2:0] y;
  cls_e       cls;
  logic [7:0] src;
  logic [7:0] sh_res;
  logic       sh_c;
  logic [7:0] bit_mask;

  assign sel      = item_i.opcode[2:0];
  assign y        = item_i.opcode[5:3];
  assign cls      = cls_e'(item_i.opcode[7:6]);
  assign bit_mask = 8'(1) << y;

  // single read port: operand on execute, reg_index otherwise
  assign rf_raddr_o = (item_i.op == OP_EXEC) ? slot_of(sel) : slot_of(item_i.reg_index);
  assign src        = (sel == SelMem) ? item_i.mem_byte : rf_rdata_i;

  // shift and rotate kinds
  always_comb begin
    unique case (shift_e'(y))
      SH_RLC:  begin sh_c = src[7]; sh_res = {src[6:0], src[7]}; end
      SH_RRC:  begin sh_c = src[0]; sh_res = {src[0], src[7:1]}; end
      SH_RL:   begin sh_c = src[7]; sh_res = {src[6:0], flags_i[0]}; end
      SH_RR:   begin sh_c = src[0]; sh_res = {flags_i[0], src[7:1]}; end
      SH_SLA:  begin sh_c = src[7]; sh_res = {src[6:0], 1'b0}; end
      SH_SRA:  begin sh_c = src[0]; sh_res = {src[7], src[7:1]}; end
      SH_SWAP: begin sh_c = 1'b0;   sh_res = {src[3:0], src[7:4]}; end
      SH_SRL:  begin sh_c = src[0]; sh_res = {1'b0, src[7:1]}; end
      default: begin sh_c = 1'b0;   sh_res = '0; end
    endcase
  end

  // item dispatch
  always_comb begin
    result_o       = '0;
    upd_o          = '0;
    upd_o.flags    = flags_i;
    upd_o.rf_waddr = rf_raddr_o;
    unique case (item_i.op)
      OP_EXEC: begin
        unique case (cls)
          CLS_SHIFT: begin
            result_o.value = sh_res;
            upd_o.flags    = {(sh_res == 8'h00), 1'b0, 1'b0, sh_c};
          end
          CLS_BIT: begin
            result_o.value = src;
            upd_o.flags    = {~src[y], 1'b0, 1'b1, flags_i[0]};
          end
          CLS_RES: result_o.value = src & ~bit_mask;
          CLS_SET: result_o.value = src | bit_mask;
          default: result_o.value = '0;
        endcase
        // modified operand goes back to memory or the register file
        if (cls != CLS_BIT) begin
          if (sel == SelMem) begin
            result_o.mem_write = 1'b1;
          end else begin
            upd_o.rf_we = 1'b1;
          end
        end
        upd_o.rf_wdata = result_o.value;
      end
      OP_LOAD: begin
        if (item_i.reg_index == RegFlags) begin
          upd_o.flags    = item_i.load_value[7:4];
          result_o.value = item_i.load_value & FlagsMask;
        end else begin
          upd_o.rf_we    = 1'b1;
          upd_o.rf_wdata = item_i.load_value;
          result_o.value = item_i.load_value;
        end
      end
      OP_READ: begin
        if (item_i.reg_index == RegFlags) begin
          result_o.value = {flags_i, 4'b0000};
        end else begin
          result_o.value = rf_rdata_i;
        end
      end
      default: result_o.value = '0;
    endcase
    result_o.flags_now = upd_o.flags;
  end

endmodule

>>> src/cb_prefix_bit_shift_unit_core.sv
// cb_prefix_bit_shift_unit_core: an input beat goes through the input register, then
// execute into the result register; throughput one beat per cycle unless the receiver
// stalls, set by the single execute stage that reads and writes the register file.
// Reset clears registers B..A, the flags and both valid bits.
// Depends on cbpsu_pkg and cbpsu_exec.
module cb_prefix_bit_shift_unit_core import cbpsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic               in_valid_q;
  in_t                in_data_q;
  logic               out_valid_q;
  out_t               out_data_q;
  logic [7:0]         rf_q [NumRegs];
  logic [3:0]         flags_q;
  logic               advance;
  logic [RegIdxW-1:0] rf_raddr;
  out_t               result;
  upd_t               upd;

  // stage moves when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  cbpsu_exec u_exec (
    .item_i     (in_data_q),
    .rf_rdata_i (rf_q[rf_raddr]),
    .flags_i    (flags_q),
    .rf_raddr_o (rf_raddr),
    .result_o   (result),
    .upd_o      (upd)
  );

  // register file and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
      flags_q <= '0;
    end else if (advance) begin
      flags_q <= upd.flags;
      if (upd.rf_we) begin
        rf_q[upd.rf_waddr] <= upd.rf_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> test/cbpsu_result_check.sv
// cbpsu_result_check: watches both channels of the prefixed bit/shift unit,
// predicts each result beat from the accepted input beats and compares them.
// Depends on cbpsu_pkg.
module cbpsu_result_check import cbpsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  // register file indexed by operand select; entry 6 (memory / flags) unused
  logic [7:0] gpr [8];
  // flags as Z N H C
  logic [3:0] flg;
  out_t       predicted_results [$];

  // apply one input beat to the shadow state, return the result it causes
  function automatic out_t run_cb_beat(input in_t it);
    out_t       r;
    logic [2:0] sel;
    logic [2:0] y;
    cls_e       cls;
    logic [7:0] src;
    logic [7:0] res;
    logic       cout;
    r   = '0;
    sel = it.opcode[2:0];
    y   = it.opcode[5:3];
    cls = cls_e'(it.opcode[7:6]);
    case (it.op)
      OP_EXEC: begin
        src = (sel == SelMem) ? it.mem_byte : gpr[sel];
        if (cls == CLS_BIT) begin
          // z is the inverse of the tested bit, h set, carry kept
          flg     = {~src[y], 1'b0, 1'b1, flg[0]};
          r.value = src;
        end else begin
          res = src;
          case (cls)
            CLS_SHIFT: begin
              case (shift_e'(y))
                SH_RLC:  begin cout = src[7]; res = {src[6:0], src[7]}; end
                SH_RRC:  begin cout = src[0]; res = {src[0], src[7:1]}; end
                SH_RL:   begin cout = src[7]; res = {src[6:0], flg[0]}; end
                SH_RR:   begin cout = src[0]; res = {flg[0], src[7:1]}; end
                SH_SLA:  begin cout = src[7]; res = {src[6:0], 1'b0}; end
                SH_SRA:  begin cout = src[0]; res = {src[7], src[7:1]}; end
                SH_SWAP: begin cout = 1'b0;   res = {src[3:0], src[7:4]}; end
                default: begin cout = src[0]; res = {1'b0, src[7:1]}; end
              endcase
              flg = {(res == 8'h00), 1'b0, 1'b0, cout};
            end
            CLS_RES: res = src & ~(8'h01 << y);
            default: res = src | (8'h01 << y);
          endcase
          // memory operand goes back for write-back, registers are updated here
          if (sel == SelMem) begin
            r.mem_write = 1'b1;
          end else begin
            gpr[sel] = res;
          end
          r.value = res;
        end
      end
      OP_LOAD: begin
        if (it.reg_index == RegFlags) begin
          flg     = it.load_value[7:4];
          r.value = {flg, 4'h0};
        end else begin
          gpr[it.reg_index] = it.load_value;
          r.value           = it.load_value;
        end
      end
      OP_READ: begin
        r.value = (it.reg_index == RegFlags) ? {flg, 4'h0} : gpr[it.reg_index];
      end
      default: r.value = 8'h00;
    endcase
    r.flags_now = flg;
    return r;
  endfunction

  // compare result beats against predictions, then queue the new prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) gpr[i] = 8'h00;
      flg = 4'h0;
      predicted_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no prediction pending: value %0h", out_data_i.value);
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data_i.value !== want.value) begin
            $error("value: expected %0h, actual %0h", want.value, out_data_i.value);
            fail_count_o++;
          end
          if (out_data_i.flags_now !== want.flags_now) begin
            $error("flags_now: expected %0h, actual %0h", want.flags_now,
                   out_data_i.flags_now);
            fail_count_o++;
          end
          if (out_data_i.mem_write !== want.mem_write) begin
            $error("mem_write: expected %0b, actual %0b", want.mem_write,
                   out_data_i.mem_write);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_results.push_back(run_cb_beat(in_data_i));
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

>>> test/tb.sv
// tb: stimulus and verdict for cb_prefix_bit_shift_unit_core.
// Drives directed then random beats under varying back-pressure.
// Depends on cbpsu_pkg, cb_prefix_bit_shift_unit_core and cbpsu_result_check.
module tb;
  import cbpsu_pkg::*;

  // plain register selects
  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegC = 3'd1;
  localparam logic [2:0] RegD = 3'd2;
  localparam logic [2:0] RegE = 3'd3;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;

  localparam int BeatsPerPhase = 434;
  localparam int StallCycles   = 50;
  localparam int DrainCycles   = 6;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  int   fail_count;
  int   pending;
  int   tx_idle_pct = 6;
  int   rx_idle_pct = 67;
  logic hold_rx     = 1'b0;

  cb_prefix_bit_shift_unit_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  cbpsu_result_check check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        for (int n = 0; n < StallCycles; n++) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [7:0] cb_opc(input cls_e cls, input logic [2:0] y,
                                        input logic [2:0] sel);
    return {cls, y, sel};
  endfunction

  function automatic in_t exec_beat(input logic [7:0] opc, input logic [7:0] mem);
    in_t b;
    b          = '0;
    b.op       = OP_EXEC;
    b.opcode   = opc;
    b.mem_byte = mem;
    return b;
  endfunction

  function automatic in_t load_beat(input logic [2:0] idx, input logic [7:0] val);
    in_t b;
    b            = '0;
    b.op         = OP_LOAD;
    b.reg_index  = idx;
    b.load_value = val;
    return b;
  endfunction

  function automatic in_t read_beat(input logic [2:0] idx);
    in_t b;
    b           = '0;
    b.op        = OP_READ;
    b.reg_index = idx;
    return b;
  endfunction

  // mostly executes, with loads and reads to steer and observe the registers
  function automatic in_t random_beat();
    in_t         b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 62) begin
      b.op = OP_EXEC;
    end else if (pick < 78) begin
      b.op = OP_LOAD;
    end else if (pick < 94) begin
      b.op = OP_READ;
    end else begin
      b.op = OP_NONE;
    end
    b.opcode     = 8'($urandom_range(255));
    b.mem_byte   = 8'($urandom_range(255));
    b.reg_index  = 3'($urandom_range(7));
    b.load_value = 8'($urandom_range(255));
    return b;
  endfunction

  // offer one beat after a random gap and wait for it to be taken
  task automatic send_beat(input in_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme values, every shift kind, bit/res/set, memory operand
    send_beat(load_beat(RegB, 8'hFF));
    send_beat(load_beat(RegC, 8'h80));
    send_beat(load_beat(RegD, 8'h01));
    send_beat(load_beat(RegE, 8'h00));
    send_beat(load_beat(RegH, 8'hA5));
    send_beat(load_beat(RegL, 8'h5A));
    send_beat(load_beat(SelA, 8'h7F));
    // flags load with low nibble set, which must be dropped
    send_beat(load_beat(RegFlags, 8'hFF));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_RLC, RegB), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_RRC, RegC), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_RL, RegD), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_RR, RegE), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_SLA, RegH), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_SRA, RegL), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_SWAP, SelMem), 8'hF0));
    send_beat(exec_beat(cb_opc(CLS_SHIFT, SH_SRL, SelA), 8'h00));
    // bit test on memory never writes back
    send_beat(exec_beat(cb_opc(CLS_BIT, 3'd7, SelMem), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_BIT, 3'd0, SelA), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_RES, 3'd7, RegB), 8'h00));
    send_beat(exec_beat(cb_opc(CLS_SET, 3'd0, SelMem), 8'h00));
    // unused op leaves everything alone
    send_beat('{op: OP_NONE, opcode: 8'hFF, mem_byte: 8'hFF, reg_index: 3'd7,
                load_value: 8'hFF});
    send_beat(read_beat(RegFlags));
    send_beat(read_beat(SelA));
    send_beat(load_beat(RegFlags, 8'h00));
    send_beat(read_beat(RegB));

    // random phases: slow receiver, slow sender, then full rate with a hold-off
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 67 : 0;
      rx_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 6 : 0;
      if (ph == 2) hold_rx = 1'b1;
      repeat (BeatsPerPhase) send_beat(random_beat());
    end
    in_valid_i <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/cbpsu_pkg.sv
src/cbpsu_exec.sv
src/cb_prefix_bit_shift_unit_core.sv
test/cbpsu_result_check.sv
test/tb.sv
